/* rtl/bss_pkg.sv */
// bss_pkg: shared types and constants for the boot slot selector
// holds the queue item format and the field codes; no dependencies
`timescale 1ns / 1ps

package bss_pkg;

    // field widths fixed by the descriptor format
    localparam int ADDR_W       = 32;
    localparam int EPOCH_W      = 32;
    localparam int SLOT_FIELD_W = 8;
    localparam int ATT_W        = 8;
    localparam int STATE_W      = 2;

    // slot lifecycle codes
    localparam logic [STATE_W-1:0] STATE_TRIAL     = 2'd1;
    localparam logic [STATE_W-1:0] STATE_CONFIRMED = 2'd2;

    // result codes
    localparam logic STATUS_SELECTED = 1'b0;
    localparam logic STATUS_NO_IMAGE = 1'b1;
    localparam logic REASON_TRIAL     = 1'b0;
    localparam logic REASON_CONFIRMED = 1'b1;

    // classified descriptor as it travels from front to back
    typedef struct packed {
        logic                    last;
        logic                    trial_ok;
        logic                    conf_ok;
        logic [EPOCH_W-1:0]      epoch;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ADDR_W-1:0]       entry;
    } t_item;

    // queue occupancy flags seen by the input handshake and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/boot_slot_selector_core.sv */
// boot_slot_selector_core: top level of the boot slot selector
// instantiates bss_front, bss_queue and bss_back; depends on bss_pkg
//
//   channel   | direction | beat carries
//   s_axis    | in        | one slot descriptor, tlast marks the final slot
//   m_axis    | out       | one selection result per list
//   cfg       | in        | minimum security epoch
//
// one descriptor per cycle sustained while the queue has room; the front classifies
// in the accept cycle and the back folds the queue head into the bests as it pops it.
// a result is captured in an output register when the back pops the last descriptor;
// only an unserved result stalls the back, and a two-entry queue keeps the input
// side moving meanwhile. synchronous active-low reset clears the bests, the queue
// and the epoch register; no clearing pass is needed.
`timescale 1ns / 1ps

module boot_slot_selector_core #(
    parameter int SLOT_ID_WIDTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [159:0]                 i_s_axis_tdata,  // is_authenticated, image_base_addr,
                                                          // image_length, entry_addr,
                                                          // slot_epoch, attempts_used,
                                                          // attempts_allowed, slot_number, pad
    input  logic [bss_pkg::STATE_W-1:0]  i_s_axis_tuser,  // slot_state
    input  logic                         i_s_axis_tlast,  // is_last
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [39:0]                  o_m_axis_tdata,  // chosen_slot, chosen_entry
    output logic [1:0]                   o_m_axis_tuser,  // status, choice_reason
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bss_pkg::EPOCH_W-1:0]  i_cfg_data
);
    import bss_pkg::*;

    logic [EPOCH_W-1:0]      r_min_epoch;
    t_item                   w_front_item;
    t_item                   w_head_item;
    t_q_status               w_q_status;
    logic                    w_pop;
    logic                    w_status;
    logic                    w_reason;
    logic [SLOT_FIELD_W-1:0] w_slot;
    logic [ADDR_W-1:0]       w_entry;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_epoch <= '0;
        end else if (i_cfg_valid) begin
            r_min_epoch <= i_cfg_data;
        end
    end

    // front: unpack and classify
    bss_front #(
        .SLOT_ID_WIDTH (SLOT_ID_WIDTH)
    ) u_front (
        .i_tdata     (i_s_axis_tdata),
        .i_tuser     (i_s_axis_tuser),
        .i_tlast     (i_s_axis_tlast),
        .i_min_epoch (r_min_epoch),
        .o_item      (w_front_item)
    );

    // queue between front and back
    assign o_s_axis_tready = !w_q_status.full;
    bss_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_s_axis_tvalid),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    // back: running bests and result
    bss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (w_head_item),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_status   (w_status),
        .o_reason   (w_reason),
        .o_slot     (w_slot),
        .o_entry    (w_entry)
    );

    // result packing
    assign o_m_axis_tdata = {w_entry, w_slot};
    assign o_m_axis_tuser = {w_reason, w_status};

endmodule

/* rtl/bss_front.sv */
// bss_front: unpacks a descriptor beat and classifies it as trial or confirmed candidate
// depends on bss_pkg
`timescale 1ns / 1ps

module bss_front #(
    parameter int SLOT_ID_WIDTH = 8
) (
    input  logic [159:0]                 i_tdata,  // auth, base, length, entry, epoch,
                                                   // used, allowed, slot, zero pad
    input  logic [bss_pkg::STATE_W-1:0]  i_tuser,  // slot_state
    input  logic                         i_tlast,  // is_last
    input  logic [bss_pkg::EPOCH_W-1:0]  i_min_epoch,
    output bss_pkg::t_item               o_item
);
    import bss_pkg::*;

    localparam int SW = (SLOT_ID_WIDTH < SLOT_FIELD_W) ? SLOT_ID_WIDTH : SLOT_FIELD_W;
    localparam logic [SLOT_FIELD_W-1:0] SLOT_MASK =
        SLOT_FIELD_W'((64'd1 << SW) - 64'd1);

    logic                    w_auth;
    logic [ADDR_W-1:0]       w_base;
    logic [ADDR_W-1:0]       w_len;
    logic [ADDR_W-1:0]       w_entry;
    logic [EPOCH_W-1:0]      w_epoch;
    logic [ATT_W-1:0]        w_used;
    logic [ATT_W-1:0]        w_allowed;
    logic [SLOT_FIELD_W-1:0] w_slot;
    logic                    w_usable;

    // field unpacking, lowest bit first
    assign w_auth    = i_tdata[0];
    assign w_base    = i_tdata[32:1];
    assign w_len     = i_tdata[64:33];
    assign w_entry   = i_tdata[96:65];
    assign w_epoch   = i_tdata[128:97];
    assign w_used    = i_tdata[136:129];
    assign w_allowed = i_tdata[144:137];
    assign w_slot    = i_tdata[152:145] & SLOT_MASK;

    // common eligibility
    assign w_usable = w_auth && (w_base != '0) && (w_len != '0) && (w_entry != '0)
                      && (w_epoch >= i_min_epoch);

    // classification into the queue item
    always_comb begin
        o_item.last     = i_tlast;
        o_item.trial_ok = w_usable && (i_tuser == STATE_TRIAL) && (w_used < w_allowed);
        o_item.conf_ok  = w_usable && (i_tuser == STATE_CONFIRMED);
        o_item.epoch    = w_epoch;
        o_item.slot     = w_slot;
        o_item.entry    = w_entry;
    end

endmodule

/* rtl/bss_queue.sv */
// bss_queue: two-entry queue of classified descriptors between front and back
// depends on bss_pkg
`timescale 1ns / 1ps

module bss_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bss_pkg::t_item      i_item,
    input  logic                i_pop,
    output bss_pkg::t_item      o_item,
    output bss_pkg::t_q_status  o_status
);
    import bss_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_item = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ w_pop;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/bss_back.sv */
// bss_back: keeps the running best trial and confirmed slots and forms the result
// depends on bss_pkg
`timescale 1ns / 1ps

module bss_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bss_pkg::t_item                      i_item,
    input  bss_pkg::t_q_status                  i_q_status,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_status,
    output logic                                o_reason,
    output logic [bss_pkg::SLOT_FIELD_W-1:0]    o_slot,
    output logic [bss_pkg::ADDR_W-1:0]          o_entry
);
    import bss_pkg::*;

    // running bests
    logic                    r_tf, n_tf;
    logic [EPOCH_W-1:0]      r_te, n_te;
    logic [SLOT_FIELD_W-1:0] r_ts, n_ts;
    logic [ADDR_W-1:0]       r_tn, n_tn;
    logic                    r_cf, n_cf;
    logic [EPOCH_W-1:0]      r_ce, n_ce;
    logic [SLOT_FIELD_W-1:0] r_cs, n_cs;
    logic [ADDR_W-1:0]       r_cn, n_cn;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic                    r_status, n_status;
    logic                    r_reason, n_reason;
    logic [SLOT_FIELD_W-1:0] r_slot, n_slot;
    logic [ADDR_W-1:0]       r_entry, n_entry;

    logic w_head;
    logic w_out_free;
    logic w_t_take;
    logic w_c_take;
    logic w_emit;

    assign w_head     = !i_q_status.empty;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = w_head && (!i_item.last || w_out_free);
    assign w_emit     = o_pop && i_item.last;

    // candidate beats held best
    assign w_t_take = i_item.trial_ok && (!r_tf || (i_item.epoch > r_te)
                      || ((i_item.epoch == r_te) && (i_item.slot < r_ts)));
    assign w_c_take = i_item.conf_ok && (!r_cf || (i_item.epoch > r_ce)
                      || ((i_item.epoch == r_ce) && (i_item.slot < r_cs)));

    // best update, result pick and clear after the last beat
    always_comb begin
        n_tf = r_tf; n_te = r_te; n_ts = r_ts; n_tn = r_tn;
        n_cf = r_cf; n_ce = r_ce; n_cs = r_cs; n_cn = r_cn;
        n_out_valid = r_out_valid && !i_ready;
        n_status = r_status;
        n_reason = r_reason;
        n_slot   = r_slot;
        n_entry  = r_entry;
        if (o_pop) begin
            if (w_t_take) begin
                n_tf = 1'b1; n_te = i_item.epoch; n_ts = i_item.slot; n_tn = i_item.entry;
            end
            if (w_c_take) begin
                n_cf = 1'b1; n_ce = i_item.epoch; n_cs = i_item.slot; n_cn = i_item.entry;
            end
        end
        if (w_emit) begin
            n_out_valid = 1'b1;
            if (n_tf) begin
                n_status = STATUS_SELECTED; n_reason = REASON_TRIAL;
                n_slot   = n_ts;            n_entry  = n_tn;
            end else if (n_cf) begin
                n_status = STATUS_SELECTED; n_reason = REASON_CONFIRMED;
                n_slot   = n_cs;            n_entry  = n_cn;
            end else begin
                n_status = STATUS_NO_IMAGE; n_reason = REASON_TRIAL;
                n_slot   = '0;              n_entry  = '0;
            end
            n_tf = 1'b0; n_te = '0; n_ts = '0; n_tn = '0;
            n_cf = 1'b0; n_ce = '0; n_cs = '0; n_cn = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tf <= 1'b0; r_te <= '0; r_ts <= '0; r_tn <= '0;
            r_cf <= 1'b0; r_ce <= '0; r_cs <= '0; r_cn <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tf <= n_tf; r_te <= n_te; r_ts <= n_ts; r_tn <= n_tn;
            r_cf <= n_cf; r_ce <= n_ce; r_cs <= n_cs; r_cn <= n_cn;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_reason <= n_reason;
        r_slot   <= n_slot;
        r_entry  <= n_entry;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_reason = r_reason;
    assign o_slot   = r_slot;
    assign o_entry  = r_entry;

endmodule
